// ===== sv/rse_pkg.sv =====
// ----------------------------------------------------------------------------
// rse_pkg: shared definitions for the RPN stack evaluator
// Holds the stack geometry, the token and status codes, the controller
// states and the stack memory write bundle.
// ----------------------------------------------------------------------------
package rse_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

   // Token kinds.
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_LONG = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // Operator symbols.
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_STAR  = 8'h2A;
   localparam logic [7:0] SYM_SLASH = 8'h2F;
   localparam logic [7:0] SYM_ZERO  = 8'h30;
   localparam logic [7:0] SYM_NINE  = 8'h39;

   // Result status codes.
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FEW   = 3'd1;
   localparam logic [2:0] ST_DIV0  = 3'd2;
   localparam logic [2:0] ST_BADOP = 3'd3;
   localparam logic [2:0] ST_LONG  = 3'd4;
   localparam logic [2:0] ST_COUNT = 3'd5;
   localparam logic [2:0] ST_OVER  = 3'd6;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_DIV,
      S_OUT
   } state_type;

   // Write port bundle of the stack memory.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } ram_wr_type;

endpackage

// ===== sv/rse_channels.sv =====
// ----------------------------------------------------------------------------
// rse_channels: valid/ready channels of the RPN stack evaluator
// One interface for token items and one for result items.
// ----------------------------------------------------------------------------
interface rse_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] symbol;

   modport source (output valid, output kind, output symbol, input ready);
   modport sink   (input valid, input kind, input symbol, output ready);
endinterface

interface rse_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] value;
   logic               done_res;

   modport source (output valid, output status, output value, output done_res,
                   input ready);
   modport sink   (input valid, input status, input value, input done_res,
                   output ready);
endinterface

// ===== sv/rse_stack_ram.sv =====
// ----------------------------------------------------------------------------
// rse_stack_ram: operand stack storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rse_stack_ram (
   input  logic                             clock,
   input  rse_pkg::ram_wr_type              wr,
   input  logic                             rd_en,
   input  logic [rse_pkg::ADDR_W-1:0]       rd_addr,
   output logic [rse_pkg::DATA_W-1:0]       rd_data
);

   logic [rse_pkg::DATA_W-1:0] mem [rse_pkg::STACK_DEPTH];
   logic [rse_pkg::DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rse_divider.sv =====
// ----------------------------------------------------------------------------
// rse_divider: signed 32-bit divider, truncating toward zero
// Restoring radix-2 division on magnitudes, one quotient bit per cycle;
// done pulses when the quotient is ready. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module rse_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   // One restoring step per cycle; operands enter as magnitudes.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      shifted = {1'b0, rem_ff} << 1;
      shifted[0] = quo_ff[31];
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = 5'd31;
         rem_in  = '0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         dvs_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule

// ===== sv/rpn_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator: reverse Polish calculator on a bounded operand stack
// Digits, end items, long tokens, held errors, few operands and overflow go
// straight to the result register; '+', '-', '*', bad operators and zero
// divisors first take one stack memory read; '/' then waits for the 32-step
// divider. A new item is taken only in idle, after the last result has moved
// to the output register. Reset clears the count, the held error and the
// output valid flag; stack memory is left as is, no clearing pass is needed.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
   input  logic            clock,
   input  logic            reset,
   rse_req_if.sink         req_chan,
   rse_rsp_if.source       rsp_chan
);

   localparam int CW = rse_pkg::CNT_W;
   localparam int AW = rse_pkg::ADDR_W;

   rse_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [2:0]         err_ff, err_in;
   logic [31:0]        top_ff, top_in;
   logic [7:0]         sym_ff, sym_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [31:0]        res_value_ff, res_value_in;
   logic               res_done_ff, res_done_in;
   logic               out_valid_ff, out_valid_in;
   logic [2:0]         out_status_ff;
   logic [31:0]        out_value_ff;
   logic               out_done_ff;
   logic               load_out;
   logic               accept;

   rse_pkg::ram_wr_type ram_wr;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [31:0]         ram_rd_data;
   logic [CW-1:0]       cnt_less1;
   logic [CW-1:0]       cnt_less2;
   logic [31:0]         product;

   logic                div_start;
   logic                div_done;
   logic [31:0]         div_quo;

   // Stack storage; the top entry is cached in top_ff, the rest live here.
   rse_stack_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Iterative divider.
   rse_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ram_rd_data),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign cnt_less1 = count_ff - CW'(1);
   assign cnt_less2 = count_ff - CW'(2);
   assign product   = ram_rd_data * top_ff;
   assign accept    = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == rse_pkg::S_IDLE);

   // Next state, stack update and result selection.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      sym_in        = sym_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_done_in   = res_done_ff;
      ram_wr.en     = 1'b0;
      ram_wr.addr   = cnt_less1[AW-1:0];
      ram_wr.data   = top_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cnt_less2[AW-1:0];
      div_start     = 1'b0;
      load_out      = 1'b0;
      case (state_ff)
         rse_pkg::S_IDLE: begin
            if (accept) begin
               sym_in        = req_chan.symbol;
               res_done_in   = 1'b0;
               res_value_in  = '0;
               res_status_in = err_ff;
               state_in      = rse_pkg::S_OUT;
               case (req_chan.kind)
                  rse_pkg::KIND_END: begin
                     res_done_in = 1'b1;
                     if (err_ff != rse_pkg::ST_OK) begin
                        res_status_in = err_ff;
                     end else if (count_ff != CW'(1)) begin
                        res_status_in = rse_pkg::ST_COUNT;
                     end else begin
                        res_status_in = rse_pkg::ST_OK;
                        res_value_in  = top_ff;
                     end
                     count_in = '0;
                     err_in   = rse_pkg::ST_OK;
                  end
                  rse_pkg::KIND_LONG: begin
                     if (err_ff == rse_pkg::ST_OK) begin
                        err_in        = rse_pkg::ST_LONG;
                        res_status_in = rse_pkg::ST_LONG;
                     end
                  end
                  rse_pkg::KIND_CHAR: begin
                     if (err_ff != rse_pkg::ST_OK) begin
                        res_status_in = err_ff;
                     end else if (req_chan.symbol inside
                                  {[rse_pkg::SYM_ZERO:rse_pkg::SYM_NINE]}) begin
                        if (count_ff >= rse_pkg::DEPTH_CNT) begin
                           err_in        = rse_pkg::ST_OVER;
                           res_status_in = rse_pkg::ST_OVER;
                        end else begin
                           // Push: spill the cached top, then load the digit.
                           ram_wr.en     = (count_ff != '0);
                           top_in        = {28'd0, req_chan.symbol[3:0]};
                           count_in      = count_ff + CW'(1);
                           res_status_in = rse_pkg::ST_OK;
                           res_value_in  = {28'd0, req_chan.symbol[3:0]};
                        end
                     end else if (count_ff < CW'(2)) begin
                        err_in        = rse_pkg::ST_FEW;
                        res_status_in = rse_pkg::ST_FEW;
                     end else begin
                        // Fetch the second operand from below the top.
                        ram_rd_en = 1'b1;
                        state_in  = rse_pkg::S_READ;
                     end
                  end
                  default: begin
                     // Meaningless kind: report like a token, change nothing.
                     if (err_ff == rse_pkg::ST_OK && count_ff != '0) begin
                        res_value_in = top_ff;
                     end
                  end
               endcase
            end
         end
         rse_pkg::S_READ: begin
            state_in      = rse_pkg::S_OUT;
            res_status_in = rse_pkg::ST_OK;
            res_value_in  = '0;
            case (sym_ff)
               rse_pkg::SYM_PLUS: begin
                  res_value_in = ram_rd_data + top_ff;
               end
               rse_pkg::SYM_MINUS: begin
                  res_value_in = ram_rd_data - top_ff;
               end
               rse_pkg::SYM_STAR: begin
                  res_value_in = product;
               end
               rse_pkg::SYM_SLASH: begin
                  if (top_ff == '0) begin
                     res_status_in = rse_pkg::ST_DIV0;
                  end else begin
                     div_start = 1'b1;
                     state_in  = rse_pkg::S_DIV;
                  end
               end
               default: begin
                  res_status_in = rse_pkg::ST_BADOP;
               end
            endcase
            if (res_status_in != rse_pkg::ST_OK) begin
               err_in = res_status_in;
            end else if (state_in == rse_pkg::S_OUT) begin
               top_in   = res_value_in;
               count_in = cnt_less1;
            end
         end
         rse_pkg::S_DIV: begin
            if (div_done) begin
               res_status_in = rse_pkg::ST_OK;
               res_value_in  = div_quo;
               top_in        = div_quo;
               count_in      = cnt_less1;
               state_in      = rse_pkg::S_OUT;
            end
         end
         rse_pkg::S_OUT: begin
            // Hand the result over once the output register is free.
            if (!out_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = rse_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rse_pkg::S_IDLE;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rse_pkg::S_IDLE;
         count_ff     <= '0;
         err_ff       <= rse_pkg::ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      sym_ff        <= sym_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_done_ff   <= res_done_in;
      if (load_out) begin
         out_status_ff <= res_status_ff;
         out_value_ff  <= res_value_ff;
         out_done_ff   <= res_done_ff;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.status   = out_status_ff;
   assign rsp_chan.value    = out_value_ff;
   assign rsp_chan.done_res = out_done_ff;

   // The stack count never passes the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rse_pkg::DEPTH_CNT)
      else $error("stack count beyond depth");

   // An operand fetch only happens with two operands and no held error.
   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      state_ff == rse_pkg::S_READ |-> err_ff == rse_pkg::ST_OK && count_ff >= CW'(2))
      else $error("operand fetch without two operands");

   // The divider finishes only while the controller waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == rse_pkg::S_DIV)
      else $error("divider result outside divide state");

   // A result is loaded only into a free or draining output register.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load_out |-> !out_valid_ff || rsp_chan.ready)
      else $error("result register overrun");

endmodule
